// ----- hdl/mbwu_pkg.sv -----
`default_nettype none
package mbwu_pkg;

  localparam int DATA_W     = 16;
  localparam int FRAC_BITS  = 12;
  localparam int NEURONS    = 16;
  localparam int W_ADDR_W   = 10;
  localparam int W_DEPTH    = 768;
  localparam int V_ADDR_W   = 6;
  localparam int V_DEPTH    = 64;
  localparam int OP_W       = 17;
  localparam int PROD_W     = 34;
  localparam int ACC_W      = 40;

  typedef enum logic [2:0] {
    FN_WR_WEIGHT = 3'd0,
    FN_IN_VALUE  = 3'd1,
    FN_ACT_VALUE = 3'd2,
    FN_DERIV     = 3'd3,
    FN_ERROR     = 3'd4,
    FN_RUN       = 3'd5,
    FN_RD_WEIGHT = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    REG_NUM_LAYERS = 3'd0,
    REG_SIZE_ZERO  = 3'd1,
    REG_SIZE_ONE   = 3'd2,
    REG_SIZE_TWO   = 3'd3,
    REG_SIZE_THREE = 3'd4,
    REG_LRATE      = 3'd5,
    REG_MOMENTUM   = 3'd6
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_G_RD,
    ST_G_MUL,
    ST_G_WR,
    ST_B_RD,
    ST_B_MUL,
    ST_B_ACC,
    ST_B_DRD,
    ST_B_DMUL,
    ST_B_DWR,
    ST_U_RD,
    ST_U_M1,
    ST_U_M2,
    ST_U_M3,
    ST_U_WR,
    ST_NEXT_MAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_add;
  } mac_ctl_t;

  // Arithmetic shift right by the fraction bits (rounds toward minus
  // infinity), then saturate to a signed data word.
  function automatic logic signed [DATA_W-1:0] shr_sat(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] t;
    t = x >>> FRAC_BITS;
    if (t > ACC_W'(32767)) begin
      return 16'sh7fff;
    end else if (t < -ACC_W'(32768)) begin
      return 16'sh8000;
    end
    return t[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (d[DATA_W] != d[DATA_W-1]) begin
      return d[DATA_W] ? 16'sh8000 : 16'sh7fff;
    end
    return d[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/mbwu_ram.sv -----
`default_nettype none
module mbwu_ram #(
  parameter int ADDR_W = 10,
  parameter int DEPTH  = 768
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [15:0]       wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [15:0]       rdata_r
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mbwu_mac.sv -----
`default_nettype none
module mbwu_mac
  import mbwu_pkg::*;
(
  input  wire logic                     clk,
  input  wire mac_ctl_t                 ctl,
  input  wire logic signed [OP_W-1:0]   op_a,
  input  wire logic signed [OP_W-1:0]   op_b,
  output logic signed [DATA_W-1:0]      q_prod,
  output logic signed [DATA_W-1:0]      q_acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_add) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign q_prod = shr_sat(ACC_W'(prod_r));
  assign q_acc  = shr_sat(acc_r);

endmodule
`default_nettype wire

// ----- hdl/mlp_backprop_weight_update.sv -----
`default_nettype none
// Back-propagation weight update for a small fully connected network in
// signed Q4.12. Load items (write weight, layer value, derivative, output
// error) and the read item are transferred one at a time; a load finishes
// in the cycle it is accepted and its result is shown the next cycle, and a
// read result passes through the registered read port of the weight RAM
// and then the output register. A run item is worked by a sequencer around
// one shared 17x17 multiplier with an accumulator and one weight RAM with
// a single read port and a single write port. Each weight update reads the
// weight and the layer value, makes three multiplications on the shared
// unit and writes the weight back. Weights are updated in place: for each
// matrix above the lowest the gradients of the layer below are formed first
// from the old weights, then the matrix is rewritten, so no staging copy is
// needed. The block accepts no item until the run's result is transferred.
// Configuration writes are accepted in any cycle and must only be issued
// while the block is idle.
module mlp_backprop_weight_update
  import mbwu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_func,
  input  wire logic [1:0]         in_layer,
  input  wire logic [3:0]         in_row,
  input  wire logic [3:0]         in_col,
  input  wire logic signed [15:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_read_value,
  output logic                    out_status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [14:0]        cfg_data
);

  // Configuration registers and their clamped views.
  logic [2:0]  num_layers_r;
  logic [4:0]  size0_r, size1_r, size2_r, size3_r;
  logic [14:0] lrate_r, mom_r;
  logic [2:0]  num_eff;
  logic [4:0]  se0, se1, se2, se3;
  logic [1:0]  top_layer;

  function automatic logic [4:0] clamp_size(input logic [4:0] s);
    if (s == 5'd0) begin
      return 5'd1;
    end else if (s > 5'd16) begin
      return 5'd16;
    end
    return s;
  endfunction

  function automatic logic [4:0] pick(input logic [1:0] i, input logic [4:0] a,
                                      input logic [4:0] b, input logic [4:0] c,
                                      input logic [4:0] d);
    logic [4:0] s;
    case (i)
      2'd0:    s = a;
      2'd1:    s = b;
      2'd2:    s = c;
      default: s = d;
    endcase
    return s;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_layers_r <= 3'd3;
      size0_r      <= 5'd16;
      size1_r      <= 5'd16;
      size2_r      <= 5'd16;
      size3_r      <= 5'd16;
      lrate_r      <= 15'd410;
      mom_r        <= 15'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NUM_LAYERS: num_layers_r <= cfg_data[2:0];
        REG_SIZE_ZERO:  size0_r      <= cfg_data[4:0];
        REG_SIZE_ONE:   size1_r      <= cfg_data[4:0];
        REG_SIZE_TWO:   size2_r      <= cfg_data[4:0];
        REG_SIZE_THREE: size3_r      <= cfg_data[4:0];
        REG_LRATE:      lrate_r      <= cfg_data;
        REG_MOMENTUM:   mom_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign num_eff   = (num_layers_r < 3'd2) ? 3'd2 :
                     (num_layers_r > 3'd4) ? 3'd4 : num_layers_r;
  assign top_layer = 2'(num_eff - 3'd1);
  assign se0 = clamp_size(size0_r);
  assign se1 = clamp_size(size1_r);
  assign se2 = clamp_size(size2_r);
  assign se3 = clamp_size(size3_r);

  // Index checks for incoming items.
  logic [4:0] sz_lay, sz_up, sz_top;
  logic       wok, vok, eok, accept;

  assign sz_lay = pick(in_layer, se0, se1, se2, se3);
  assign sz_up  = pick(in_layer + 2'd1, se0, se1, se2, se3);
  assign sz_top = pick(top_layer, se0, se1, se2, se3);
  assign wok = (({1'b0, in_layer} + 3'd1) < num_eff) && ({1'b0, in_row} < sz_lay) &&
               ({1'b0, in_col} < sz_up);
  assign vok = ({1'b0, in_layer} < num_eff) && ({1'b0, in_row} < sz_lay);
  assign eok = {1'b0, in_row} < sz_top;
  assign accept = in_valid && in_ready;

  // Sequencer state and loop counters.
  state_t     state_r, state_nxt;
  logic [1:0] m_r;
  logic [3:0] r_r, c_r;
  logic [3:0] nt_last, nl_last, nu_last;
  logic       c_end, r_end;

  assign nt_last = 4'(sz_top - 5'd1);
  assign nl_last = 4'(pick(m_r, se0, se1, se2, se3) - 5'd1);
  assign nu_last = 4'(pick(m_r + 2'd1, se0, se1, se2, se3) - 5'd1);
  assign c_end   = (c_r == nu_last);
  assign r_end   = (r_r == nl_last);

  // Small vectors held in flops.
  logic signed [15:0] err_r   [NEURONS];
  logic signed [15:0] g_up_r  [NEURONS];
  logic signed [15:0] g_low_r [NEURONS];
  logic signed [15:0] kept_r;

  // Memory ports.
  logic                w_we, w_re;
  logic [W_ADDR_W-1:0] w_waddr, w_raddr;
  logic [15:0]         w_wdata, w_rdata;
  logic                v_we, v_re;
  logic [V_ADDR_W-1:0] v_raddr;
  logic [15:0]         v_rdata;
  logic                d_we, d_re;
  logic [V_ADDR_W-1:0] d_raddr;
  logic [15:0]         d_rdata;

  // Shared multiply unit.
  mac_ctl_t                 mac_ctl;
  logic signed [OP_W-1:0]   mac_a, mac_b;
  logic signed [DATA_W-1:0] q_prod, q_acc;

  // Sequencer strobes.
  logic               err_we, gup_we, glow_we, kept_we, g_copy;
  logic               res_set, res_stat;
  logic signed [15:0] res_val;

  // Output register.
  logic               out_valid_r, out_status_r;
  logic signed [15:0] out_read_value_r;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FN_RUN) begin
            state_nxt = ST_G_RD;
          end else if (in_func == FN_RD_WEIGHT && wok) begin
            state_nxt = ST_RD_WAIT;
          end
        end
      end
      ST_RD_WAIT: state_nxt = ST_IDLE;
      ST_G_RD:    state_nxt = ST_G_MUL;
      ST_G_MUL:   state_nxt = ST_G_WR;
      ST_G_WR: begin
        if (c_r == nt_last) begin
          state_nxt = (num_eff > 3'd2) ? ST_B_RD : ST_U_RD;
        end else begin
          state_nxt = ST_G_RD;
        end
      end
      ST_B_RD:    state_nxt = ST_B_MUL;
      ST_B_MUL:   state_nxt = ST_B_ACC;
      ST_B_ACC:   state_nxt = c_end ? ST_B_DRD : ST_B_RD;
      ST_B_DRD:   state_nxt = ST_B_DMUL;
      ST_B_DMUL:  state_nxt = ST_B_DWR;
      ST_B_DWR:   state_nxt = r_end ? ST_U_RD : ST_B_RD;
      ST_U_RD:    state_nxt = ST_U_M1;
      ST_U_M1:    state_nxt = ST_U_M2;
      ST_U_M2:    state_nxt = ST_U_M3;
      ST_U_M3:    state_nxt = ST_U_WR;
      ST_U_WR:    state_nxt = (c_end && r_end) ? ST_NEXT_MAT : ST_U_RD;
      ST_NEXT_MAT: begin
        if (m_r == 2'd0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = (m_r > 2'd1) ? ST_B_RD : ST_U_RD;
        end
      end
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    w_we = 1'b0; w_re = 1'b0; w_waddr = '0; w_raddr = '0; w_wdata = '0;
    v_we = 1'b0; v_re = 1'b0; v_raddr = '0;
    d_we = 1'b0; d_re = 1'b0; d_raddr = '0;
    mac_ctl = '0; mac_a = '0; mac_b = '0;
    err_we = 1'b0; gup_we = 1'b0; glow_we = 1'b0; kept_we = 1'b0; g_copy = 1'b0;
    res_set = 1'b0; res_stat = 1'b0; res_val = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        w_waddr  = {in_layer, in_row, in_col};
        w_raddr  = {in_layer, in_row, in_col};
        w_wdata  = in_value;
        if (accept) begin
          res_set = 1'b1;
          case (in_func)
            FN_WR_WEIGHT: begin
              w_we     = wok;
              res_stat = !wok;
            end
            FN_IN_VALUE, FN_ACT_VALUE: begin
              v_we     = vok;
              res_stat = !vok;
            end
            FN_DERIV: begin
              d_we     = vok;
              res_stat = !vok;
            end
            FN_ERROR: begin
              err_we   = eok;
              res_stat = !eok;
            end
            FN_RUN: begin
              res_set = 1'b0;
            end
            FN_RD_WEIGHT: begin
              w_re     = wok;
              res_set  = !wok;
              res_stat = !wok;
            end
            default: res_stat = 1'b1;
          endcase
        end
      end
      ST_RD_WAIT: begin
        res_set = 1'b1;
        res_val = w_rdata;
      end
      ST_G_RD: begin
        d_re    = 1'b1;
        d_raddr = {top_layer, c_r};
      end
      ST_G_MUL: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = OP_W'(err_r[c_r]);
        mac_b = OP_W'($signed(d_rdata));
      end
      ST_G_WR: gup_we = 1'b1;
      ST_B_RD: begin
        w_re    = 1'b1;
        w_raddr = {m_r, r_r, c_r};
        mac_ctl.acc_clr = (c_r == 4'd0);
      end
      ST_B_MUL: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = OP_W'(g_up_r[c_r]);
        mac_b = OP_W'($signed(w_rdata));
      end
      ST_B_ACC: mac_ctl.acc_add = 1'b1;
      ST_B_DRD: begin
        d_re    = 1'b1;
        d_raddr = {m_r, r_r};
      end
      ST_B_DMUL: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = OP_W'(q_acc);
        mac_b = OP_W'($signed(d_rdata));
      end
      ST_B_DWR: glow_we = 1'b1;
      ST_U_RD: begin
        w_re    = 1'b1;
        w_raddr = {m_r, r_r, c_r};
        v_re    = 1'b1;
        v_raddr = {m_r, r_r};
      end
      ST_U_M1: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = {2'b00, mom_r};
        mac_b = OP_W'($signed(w_rdata));
      end
      ST_U_M2: begin
        kept_we = 1'b1;
        mac_ctl.mul_en = 1'b1;
        mac_a = OP_W'(g_up_r[c_r]);
        mac_b = OP_W'($signed(v_rdata));
      end
      ST_U_M3: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = {2'b00, lrate_r};
        mac_b = OP_W'(q_prod);
      end
      ST_U_WR: begin
        w_we    = 1'b1;
        w_waddr = {m_r, r_r, c_r};
        w_wdata = sub_sat(kept_r, q_prod);
      end
      ST_NEXT_MAT: g_copy = 1'b1;
      ST_DONE: res_set = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      m_r         <= '0;
      r_r         <= '0;
      c_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (res_set) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          c_r <= '0;
          r_r <= '0;
        end
        ST_G_WR: begin
          if (c_r == nt_last) begin
            c_r <= '0;
            r_r <= '0;
            m_r <= 2'(top_layer - 2'd1);
          end else begin
            c_r <= c_r + 4'd1;
          end
        end
        ST_B_ACC: c_r <= c_end ? 4'd0 : c_r + 4'd1;
        ST_B_DWR: r_r <= r_end ? 4'd0 : r_r + 4'd1;
        ST_U_WR: begin
          if (c_end) begin
            c_r <= '0;
            r_r <= r_end ? 4'd0 : r_r + 4'd1;
          end else begin
            c_r <= c_r + 4'd1;
          end
        end
        ST_NEXT_MAT: begin
          if (m_r != 2'd0) begin
            m_r <= m_r - 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (res_set) begin
      out_read_value_r <= res_val;
      out_status_r     <= res_stat;
    end
    if (err_we) begin
      err_r[in_row] <= in_value;
    end
    if (gup_we) begin
      g_up_r[c_r] <= q_prod;
    end
    if (glow_we) begin
      g_low_r[r_r] <= q_prod;
    end
    if (g_copy) begin
      g_up_r <= g_low_r;
    end
    if (kept_we) begin
      kept_r <= q_prod;
    end
  end

  mbwu_ram #(.ADDR_W(W_ADDR_W), .DEPTH(W_DEPTH)) u_weights (
    .clk     (clk),
    .we      (w_we),
    .waddr   (w_waddr),
    .wdata   (w_wdata),
    .re      (w_re),
    .raddr   (w_raddr),
    .rdata_r (w_rdata)
  );

  mbwu_ram #(.ADDR_W(V_ADDR_W), .DEPTH(V_DEPTH)) u_values (
    .clk     (clk),
    .we      (v_we),
    .waddr   ({in_layer, in_row}),
    .wdata   (in_value),
    .re      (v_re),
    .raddr   (v_raddr),
    .rdata_r (v_rdata)
  );

  mbwu_ram #(.ADDR_W(V_ADDR_W), .DEPTH(V_DEPTH)) u_derivs (
    .clk     (clk),
    .we      (d_we),
    .waddr   ({in_layer, in_row}),
    .wdata   (in_value),
    .re      (d_re),
    .raddr   (d_raddr),
    .rdata_r (d_rdata)
  );

  mbwu_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .q_prod (q_prod),
    .q_acc  (q_acc)
  );

`ifndef SYNTHESIS
  // A result only appears after an accepted item, a read or a finished run.
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(accept) || $past(state_r) == ST_RD_WAIT ||
                            $past(state_r) == ST_DONE))
    else $error("result transfer without a cause");

  // The weight RAM is never read and written at the same address in one cycle.
  a_w_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (w_we && w_re) |-> (w_waddr != w_raddr))
    else $error("weight RAM read/write collision");

  // Updates only touch configured matrices.
  a_mat_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_U_WR) |-> (({1'b0, m_r} + 3'd2) <= num_eff))
    else $error("weight update beyond configured matrices");

  // Gradients are never propagated below the first hidden layer.
  a_bp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_B_DMUL) |-> (m_r != 2'd0))
    else $error("back-propagation through the input matrix");
`endif

endmodule
`default_nettype wire
